### rtl/core/pbrq_pkg.sv
package pbrq_pkg;

   localparam int THREAD_W = 6;
   localparam int PRIO_W   = 6;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 16;

   typedef enum logic [1:0] {
      OP_APPEND   = 2'd0,
      OP_PREPEND  = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_SCHEDULE = 2'd3
   } pbrq_op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NOT_FOUND  = 2'd1,
      ST_NOTHING    = 2'd2,
      ST_QUEUED     = 2'd3
   } pbrq_status_type;

   typedef enum logic [1:0] {
      SEL_NONE   = 2'd0,
      SEL_THREAD = 2'd1,
      SEL_HEAD   = 2'd2
   } pbrq_sel_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_READ_INS,
      CMD_INS,
      CMD_READ_REM,
      CMD_REM,
      CMD_READ_POP,
      CMD_LATCH_POP,
      CMD_POP,
      CMD_LOAD_RSP
   } pbrq_cmd_type;

   typedef struct packed {
      pbrq_cmd_type    cmd;
      pbrq_status_type res_status;
      pbrq_sel_type    res_sel;
   } pbrq_ctl_type;

   typedef struct packed {
      pbrq_op_type op;
      logic        t_ok;
      logic        queued;
      logic        lvl_busy;
      logic        top_valid;
      logic        lvl_ge_top;
      logic        active;
      logic        enabled;
      logic        tl_match;
   } pbrq_stat_type;

endpackage

### rtl/core/pbrq_ram.sv
module pbrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/pbrq_ctrl.sv
module pbrq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  pbrq_pkg::pbrq_stat_type stat,
   output pbrq_pkg::pbrq_ctl_type  ctl
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_INS, S_REM, S_POP_RD, S_POP_NX, S_POP, S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic                      sched_ff, sched_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   pbrq_pkg::pbrq_status_type res_status_ff, res_status_in;
   pbrq_pkg::pbrq_sel_type    res_sel_ff, res_sel_in;
   logic                      load;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      sched_in       = sched_ff;
      res_status_in  = res_status_ff;
      res_sel_in     = res_sel_ff;
      rsp_valid_in   = rsp_valid_ff;
      ctl.cmd        = pbrq_pkg::CMD_NONE;
      ctl.res_status = res_status_ff;
      ctl.res_sel    = res_sel_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.cmd  = pbrq_pkg::CMD_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_status_in = pbrq_pkg::ST_OK;
            res_sel_in    = pbrq_pkg::SEL_NONE;
            sched_in      = 1'b0;
            state_in      = S_DONE;
            unique case (stat.op)
               pbrq_pkg::OP_APPEND, pbrq_pkg::OP_PREPEND: begin
                  if (!stat.t_ok) begin
                     res_status_in = pbrq_pkg::ST_NOT_FOUND;
                  end else if (stat.queued) begin
                     res_status_in = pbrq_pkg::ST_QUEUED;
                  end else if (!stat.lvl_busy) begin
                     ctl.cmd = pbrq_pkg::CMD_INS;
                  end else begin
                     ctl.cmd  = pbrq_pkg::CMD_READ_INS;
                     state_in = S_INS;
                  end
               end
               pbrq_pkg::OP_REMOVE: begin
                  if (!stat.t_ok || !stat.queued) begin
                     res_status_in = pbrq_pkg::ST_NOT_FOUND;
                  end else begin
                     ctl.cmd  = pbrq_pkg::CMD_READ_REM;
                     state_in = S_REM;
                  end
               end
               default: begin
                  if (stat.active && !stat.t_ok) begin
                     res_status_in = pbrq_pkg::ST_NOT_FOUND;
                  end else if (!stat.top_valid) begin
                     if (stat.active) begin
                        res_sel_in = pbrq_pkg::SEL_THREAD;
                     end else begin
                        res_status_in = pbrq_pkg::ST_NOTHING;
                     end
                  end else if (stat.active && (!stat.enabled || stat.lvl_ge_top)) begin
                     res_sel_in = pbrq_pkg::SEL_THREAD;
                  end else if (stat.active && stat.queued) begin
                     res_status_in = pbrq_pkg::ST_QUEUED;
                     res_sel_in    = pbrq_pkg::SEL_THREAD;
                  end else if (!stat.active) begin
                     state_in = S_POP_RD;
                  end else if (!stat.lvl_busy) begin
                     ctl.cmd  = pbrq_pkg::CMD_INS;
                     state_in = S_POP_RD;
                  end else begin
                     ctl.cmd  = pbrq_pkg::CMD_READ_INS;
                     sched_in = 1'b1;
                     state_in = S_INS;
                  end
               end
            endcase
         end
         S_INS: begin
            ctl.cmd  = pbrq_pkg::CMD_INS;
            state_in = sched_ff ? S_POP_RD : S_DONE;
         end
         S_REM: begin
            ctl.cmd  = pbrq_pkg::CMD_REM;
            state_in = S_DONE;
            if (stat.tl_match) begin
               res_sel_in = pbrq_pkg::SEL_THREAD;
            end else begin
               res_status_in = pbrq_pkg::ST_NOT_FOUND;
            end
         end
         S_POP_RD: begin
            ctl.cmd  = pbrq_pkg::CMD_READ_POP;
            state_in = S_POP_NX;
         end
         S_POP_NX: begin
            ctl.cmd  = pbrq_pkg::CMD_LATCH_POP;
            state_in = S_POP;
         end
         S_POP: begin
            ctl.cmd    = pbrq_pkg::CMD_POP;
            res_sel_in = pbrq_pkg::SEL_HEAD;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (load) begin
               ctl.cmd      = pbrq_pkg::CMD_LOAD_RSP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sched_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= pbrq_pkg::ST_OK;
         res_sel_ff    <= pbrq_pkg::SEL_NONE;
      end else begin
         state_ff      <= state_in;
         sched_ff      <= sched_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
         res_sel_ff    <= res_sel_in;
      end
   end

endmodule

### rtl/core/pbrq_datapath.sv
module pbrq_datapath #(
   parameter int PRIORITY_LEVELS = 64,
   parameter int MAX_THREADS     = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pbrq_pkg::REQ_W-1:0]          req_tdata,
   input  logic                                enabled,
   input  pbrq_pkg::pbrq_ctl_type              ctl,
   output pbrq_pkg::pbrq_stat_type             stat,
   output logic [pbrq_pkg::RSP_W-1:0]          rsp_tdata
);

   localparam int TW  = pbrq_pkg::THREAD_W;
   localparam int LEVEL_SLOTS  = (PRIORITY_LEVELS < 64) ? PRIORITY_LEVELS : 64;
   localparam int THREAD_SLOTS = (MAX_THREADS < 64) ? MAX_THREADS : 64;
   localparam int LAW = $clog2(LEVEL_SLOTS);
   localparam int TAW = $clog2(THREAD_SLOTS);

   pbrq_pkg::pbrq_op_type op_ff;
   logic [TW-1:0]         t_ff;
   logic [LAW-1:0]        lvl_ff;
   logic                  active_ff;
   logic [LAW-1:0]        top_ff;
   logic                  top_valid_ff;
   logic [TW-1:0]         pop_head_ff;
   logic [TW-1:0]         pop_tail_ff;
   logic [LEVEL_SLOTS-1:0]  bitmap_ff, bitmap_in;
   logic [THREAD_SLOTS-1:0] queued_ff, queued_in;
   logic [pbrq_pkg::RSP_W-1:0] rsp_ff;

   logic [pbrq_pkg::PRIO_W-1:0] req_prio;
   logic [LAW-1:0]  req_lvl;
   logic [LAW-1:0]  enc_top;
   logic            enc_valid;
   logic            t_ok;
   logic [TAW-1:0]  t_idx;

   logic            ht_we, nx_we, pv_we, tl_we;
   logic [LAW-1:0]  ht_wa, ht_ra;
   logic [2*TW-1:0] ht_wd, ht_rd;
   logic [TAW-1:0]  nx_wa, nx_ra, pv_wa, pv_ra, tl_ra;
   logic [TW-1:0]   nx_wd, nx_rd, pv_wd, pv_rd;
   logic [LAW-1:0]  tl_rd;
   logic [TW-1:0]   old_head, old_tail;
   logic            is_head, is_tail, tl_match;
   logic [TW-1:0]   sel;
   logic            sel_valid, switched;

   assign req_prio = req_tdata[13:8];
   assign req_lvl  = (32'(req_prio) > LEVEL_SLOTS - 1) ? LAW'(LEVEL_SLOTS - 1) : LAW'(req_prio);

   always_comb begin
      enc_top   = '0;
      enc_valid = 1'b0;
      for (int i = 0; i < LEVEL_SLOTS; i++) begin
         if (bitmap_ff[i]) begin
            enc_top   = LAW'(i);
            enc_valid = 1'b1;
         end
      end
   end

   assign t_ok     = 32'(t_ff) < MAX_THREADS;
   assign t_idx    = TAW'(t_ff);
   assign old_head = ht_rd[2*TW-1:TW];
   assign old_tail = ht_rd[TW-1:0];
   assign is_head  = (old_head == t_ff);
   assign is_tail  = (old_tail == t_ff);
   assign tl_match = (tl_rd == lvl_ff);

   assign stat.op         = op_ff;
   assign stat.t_ok       = t_ok;
   assign stat.queued     = t_ok && queued_ff[t_idx];
   assign stat.lvl_busy   = bitmap_ff[lvl_ff];
   assign stat.top_valid  = top_valid_ff;
   assign stat.lvl_ge_top = (lvl_ff >= top_ff);
   assign stat.active     = active_ff;
   assign stat.enabled    = enabled;
   assign stat.tl_match   = tl_match;

   assign ht_ra = (ctl.cmd == pbrq_pkg::CMD_READ_POP) ? top_ff : lvl_ff;
   assign tl_ra = t_idx;
   assign pv_ra = t_idx;
   assign nx_ra = (ctl.cmd == pbrq_pkg::CMD_LATCH_POP) ? TAW'(old_head) : t_idx;

   always_comb begin
      ht_we = 1'b0; ht_wa = lvl_ff; ht_wd = {t_ff, t_ff};
      nx_we = 1'b0; nx_wa = t_idx;  nx_wd = t_ff;
      pv_we = 1'b0; pv_wa = t_idx;  pv_wd = t_ff;
      tl_we = 1'b0;
      bitmap_in = bitmap_ff;
      queued_in = queued_ff;
      case (ctl.cmd)
         pbrq_pkg::CMD_INS: begin
            ht_we = 1'b1;
            tl_we = 1'b1;
            queued_in[t_idx] = 1'b1;
            if (!bitmap_ff[lvl_ff]) begin
               bitmap_in[lvl_ff] = 1'b1;
            end else if (op_ff != pbrq_pkg::OP_PREPEND) begin
               ht_wd = {old_head, t_ff};
               nx_we = 1'b1; nx_wa = TAW'(old_tail); nx_wd = t_ff;
               pv_we = 1'b1; pv_wa = t_idx;          pv_wd = old_tail;
            end else begin
               ht_wd = {t_ff, old_tail};
               pv_we = 1'b1; pv_wa = TAW'(old_head); pv_wd = t_ff;
               nx_we = 1'b1; nx_wa = t_idx;          nx_wd = old_head;
            end
         end
         pbrq_pkg::CMD_REM: begin
            if (tl_match) begin
               queued_in[t_idx] = 1'b0;
               if (is_head && is_tail) begin
                  bitmap_in[lvl_ff] = 1'b0;
               end else if (is_head) begin
                  ht_we = 1'b1; ht_wd = {nx_rd, old_tail};
               end else if (is_tail) begin
                  ht_we = 1'b1; ht_wd = {old_head, pv_rd};
               end else begin
                  nx_we = 1'b1; nx_wa = TAW'(pv_rd); nx_wd = nx_rd;
                  pv_we = 1'b1; pv_wa = TAW'(nx_rd); pv_wd = pv_rd;
               end
            end
         end
         pbrq_pkg::CMD_POP: begin
            queued_in[TAW'(pop_head_ff)] = 1'b0;
            ht_wa = top_ff;
            if (pop_head_ff == pop_tail_ff) begin
               bitmap_in[top_ff] = 1'b0;
            end else begin
               ht_we = 1'b1; ht_wd = {nx_rd, pop_tail_ff};
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      sel       = '0;
      sel_valid = 1'b0;
      switched  = 1'b0;
      case (ctl.res_sel)
         pbrq_pkg::SEL_THREAD: begin
            sel = t_ff; sel_valid = 1'b1;
         end
         pbrq_pkg::SEL_HEAD: begin
            sel = pop_head_ff; sel_valid = 1'b1;
            switched = !active_ff || (pop_head_ff != t_ff);
         end
         default: ;
      endcase
   end

   pbrq_ram #(.WIDTH(2*TW), .DEPTH(LEVEL_SLOTS)) u_head_tail (
      .clock(clock), .we(ht_we), .waddr(ht_wa), .wdata(ht_wd), .raddr(ht_ra), .rdata(ht_rd)
   );
   pbrq_ram #(.WIDTH(TW), .DEPTH(THREAD_SLOTS)) u_next (
      .clock(clock), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
   );
   pbrq_ram #(.WIDTH(TW), .DEPTH(THREAD_SLOTS)) u_prev (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
   );
   pbrq_ram #(.WIDTH(LAW), .DEPTH(THREAD_SLOTS)) u_level (
      .clock(clock), .we(tl_we), .waddr(t_idx), .wdata(lvl_ff), .raddr(tl_ra), .rdata(tl_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff <= '0;
         queued_ff <= '0;
      end else begin
         bitmap_ff <= bitmap_in;
         queued_ff <= queued_in;
      end
      if (ctl.cmd == pbrq_pkg::CMD_LATCH) begin
         op_ff        <= pbrq_pkg::pbrq_op_type'(req_tdata[1:0]);
         t_ff         <= req_tdata[7:2];
         lvl_ff       <= req_lvl;
         active_ff    <= req_tdata[14];
         top_ff       <= enc_top;
         top_valid_ff <= enc_valid;
      end
      if (ctl.cmd == pbrq_pkg::CMD_LATCH_POP) begin
         pop_head_ff <= old_head;
         pop_tail_ff <= old_tail;
      end
      if (ctl.cmd == pbrq_pkg::CMD_LOAD_RSP) begin
         rsp_ff <= {6'd0, switched, sel_valid, sel, ctl.res_status};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

### rtl/core/priority_bitmap_ready_queue_core.sv
// Ready queue for a preemptive priority scheduler: one doubly linked FIFO of
// thread ids per priority level, and a bitmap of the levels that hold threads.
// Requests arrive as beats on the req_ stream (append, prepend, remove or
// schedule) and each request gives exactly one response beat on rsp_.
// The block works on one request at a time: it takes no new request until
// the last one has been loaded into the response register. The sequencer
// steps each request through reads and writes of the head/tail, next, prev
// and level tables, which each have a single read and a single write port.
// The response sits in an output register, so a new request is taken while
// a finished response still waits; when the receiver stalls, the block holds
// the next result in its sequencer until the output register frees.
// Reset empties every level and marks every thread as not queued at once; no
// clearing pass is needed and scheduling is enabled. The scheduler_enabled
// register sits at byte address 0 of the csr_ port and may be written only
// while no request is in flight.
module priority_bitmap_ready_queue_core #(
   parameter int PRIORITY_LEVELS = 64,
   parameter int MAX_THREADS     = 64
) (
   input  logic        clock,
   input  logic        reset,
   // op[1:0], thread_id[7:2], priority_req[13:8], current_active[14]
   input  logic [15:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // status[1:0], selected_thread[7:2], selected_valid[8], switched[9]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pbrq_pkg::pbrq_ctl_type  ctl;
   pbrq_pkg::pbrq_stat_type stat;
   logic                    enabled_ff;

   // Only register 0 exists; other addresses read as zero and ignore writes.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 3'd0) ? {31'd0, enabled_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 3'd0) begin
         enabled_ff <= csr_pwdata[0];
      end
   end

   pbrq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .ctl(ctl)
   );

   pbrq_datapath #(
      .PRIORITY_LEVELS(PRIORITY_LEVELS), .MAX_THREADS(MAX_THREADS)
   ) u_datapath (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .enabled(enabled_ff),
      .ctl(ctl), .stat(stat), .rsp_tdata(rsp_tdata)
   );

endmodule

### dv/tb_priority_bitmap_ready_queue_core.sv
`timescale 1ns / 1ps

module tb_priority_bitmap_ready_queue_core;
   import pbrq_pkg::*;

   // One response beat as the checker sees it.
   typedef struct {
      pbrq_status_type status;
      logic [5:0]      sel;
      logic            sel_valid;
      logic            switched;
   } rq_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [15:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the ready queue, updated as each request beat is taken.
   logic [63:0] lvl_bitmap;
   logic [5:0]  lvl_head [64];
   logic [5:0]  lvl_tail [64];
   logic [5:0]  nxt_link [64];
   logic [5:0]  prv_link [64];
   logic [5:0]  thr_level [64];
   logic        thr_queued [64];
   logic        sched_en;
   logic [5:0]  popped_level;

   // The running thread as seen by the stimulus, so that schedules are coherent.
   logic [5:0]  run_id;
   logic [5:0]  run_prio;
   logic        run_act;

   rq_result_t  pending_rsp [$];
   int          errors = 0;
   int          snd_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          hold_cycles = 0;

   always #6 clock = ~clock;

   priority_bitmap_ready_queue_core u_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Priority encoder over the level bitmap; -1 when every level is empty.
   function automatic int highest_level();
      for (int l = 63; l >= 0; l--) begin
         if (lvl_bitmap[l]) return l;
      end
      return -1;
   endfunction

   function automatic void link_thread(logic [5:0] t, logic [5:0] l, logic at_tail);
      if (!lvl_bitmap[l]) begin
         lvl_head[l] = t;
         lvl_tail[l] = t;
         lvl_bitmap[l] = 1'b1;
      end else if (at_tail) begin
         nxt_link[lvl_tail[l]] = t;
         prv_link[t] = lvl_tail[l];
         lvl_tail[l] = t;
      end else begin
         prv_link[lvl_head[l]] = t;
         nxt_link[t] = lvl_head[l];
         lvl_head[l] = t;
      end
      thr_level[t] = l;
      thr_queued[t] = 1'b1;
   endfunction

   function automatic void unlink_thread(logic [5:0] t, logic [5:0] l);
      logic is_head;
      logic is_tail;
      is_head = (lvl_head[l] == t);
      is_tail = (lvl_tail[l] == t);
      if (is_head && is_tail) lvl_bitmap[l] = 1'b0;
      else if (is_head) lvl_head[l] = nxt_link[t];
      else if (is_tail) lvl_tail[l] = prv_link[t];
      else begin
         nxt_link[prv_link[t]] = nxt_link[t];
         prv_link[nxt_link[t]] = prv_link[t];
      end
      thr_queued[t] = 1'b0;
   endfunction

   // Works out the response to one request and applies it to the shadow queue.
   // Thread ids and levels are 6 bits, so they always lie inside the tables.
   function automatic rq_result_t predict_ready_queue(pbrq_op_type op, logic [5:0] t,
                                                      logic [5:0] l, logic act);
      rq_result_t r;
      int top;
      logic [5:0] nxt;
      r = '{ST_OK, 6'd0, 1'b0, 1'b0};
      case (op)
         OP_APPEND, OP_PREPEND: begin
            if (thr_queued[t]) r.status = ST_QUEUED;
            else link_thread(t, l, op == OP_APPEND);
         end
         OP_REMOVE: begin
            if (!thr_queued[t] || thr_level[t] != l) r.status = ST_NOT_FOUND;
            else begin
               unlink_thread(t, l);
               r.sel = t;
               r.sel_valid = 1'b1;
            end
         end
         default: begin
            top = highest_level();
            if (top < 0) begin
               if (act) begin
                  r.sel = t;
                  r.sel_valid = 1'b1;
               end else r.status = ST_NOTHING;
            end else if (act && (!sched_en || int'(l) >= top)) begin
               r.sel = t;
               r.sel_valid = 1'b1;
            end else if (act && thr_queued[t]) begin
               // A preemption would requeue a thread that is already queued.
               r.status = ST_QUEUED;
               r.sel = t;
               r.sel_valid = 1'b1;
            end else begin
               if (act) link_thread(t, l, 1'b1);
               top = highest_level();
               nxt = lvl_head[top];
               unlink_thread(nxt, 6'(top));
               popped_level = 6'(top);
               r.sel = nxt;
               r.sel_valid = 1'b1;
               r.switched = !act || nxt != t;
            end
         end
      endcase
      return r;
   endfunction

   // Offers one request beat and returns once it has been taken. The valid is
   // left high on return, so that a back-to-back beat can follow with no gap.
   task automatic send_request(pbrq_op_type op, logic [5:0] t, logic [5:0] l, logic act);
      rq_result_t r;
      if ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata  <= {1'b0, act, l, t, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      r = predict_ready_queue(op, t, l, act);
      pending_rsp.push_back(r);
      if (op == OP_SCHEDULE) begin
         if (r.sel_valid && r.status == ST_OK) begin
            if (r.switched) run_prio = popped_level;
            else if (!act) run_prio = popped_level;
            else run_prio = l;
            run_id  = r.sel;
            run_act = 1'b1;
         end else if (r.status == ST_NOTHING) run_act = 1'b0;
      end
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Register writes only happen once the block has gone quiet.
   task automatic write_sched_enable(logic v);
      drain_responses();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= {31'd0, v};
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sched_en = v;
   endtask

   task automatic test_directed_ops();
      send_request(OP_APPEND, 6'd0, 6'd0, 1'b0);
      send_request(OP_APPEND, 6'd63, 6'd63, 1'b0);
      send_request(OP_PREPEND, 6'd5, 6'd63, 1'b0);
      send_request(OP_APPEND, 6'd7, 6'd63, 1'b0);
      send_request(OP_APPEND, 6'd63, 6'd10, 1'b0);  // already queued
      send_request(OP_PREPEND, 6'd0, 6'd0, 1'b0);   // already queued
      send_request(OP_REMOVE, 6'd63, 6'd62, 1'b0);  // wrong level
      send_request(OP_REMOVE, 6'd20, 6'd0, 1'b0);   // not queued
      send_request(OP_REMOVE, 6'd63, 6'd63, 1'b1);  // middle of its level
      send_request(OP_SCHEDULE, 6'd30, 6'd1, 1'b1); // preempted by level 63
      send_request(OP_SCHEDULE, 6'd0, 6'd3, 1'b1);  // running thread already queued
      send_request(OP_SCHEDULE, 6'd12, 6'd63, 1'b1);// no higher level, stays
      send_request(OP_SCHEDULE, 6'd63, 6'd0, 1'b0); // nothing running, pop head
   endtask

   task automatic test_empty_queue();
      int t;
      for (t = 0; t < 64; t++) begin
         if (thr_queued[t]) send_request(OP_REMOVE, 6'(t), thr_level[t], 1'b0);
      end
      send_request(OP_SCHEDULE, 6'd9, 6'd4, 1'b1);  // empty, running stays
      send_request(OP_SCHEDULE, 6'd9, 6'd4, 1'b0);  // empty, nothing to run
      run_act = 1'b0;
   endtask

   task automatic test_disabled_preemption();
      write_sched_enable(1'b0);
      send_request(OP_APPEND, 6'd40, 6'd50, 1'b0);
      send_request(OP_SCHEDULE, 6'd41, 6'd0, 1'b1); // would preempt, but disabled
      send_request(OP_SCHEDULE, 6'd41, 6'd0, 1'b0); // idle processor still picks
      write_sched_enable(1'b1);
   endtask

   task automatic random_request();
      int pick;
      int t;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_request($urandom_range(99) < 70 ? OP_APPEND : OP_PREPEND,
                      6'($urandom), $urandom_range(99) < 80 ? 6'($urandom_range(7)) :
                      6'($urandom), 1'($urandom));
      end else if (pick < 55) begin
         t = $urandom_range(63);
         if ($urandom_range(99) < 80 && thr_queued[t])
            send_request(OP_REMOVE, 6'(t), thr_level[t], 1'($urandom));
         else send_request(OP_REMOVE, 6'(t), 6'($urandom), 1'($urandom));
      end else if (pick < 90) begin
         if ($urandom_range(99) < 85)
            send_request(OP_SCHEDULE, run_id, run_prio, run_act);
         else send_request(OP_SCHEDULE, 6'($urandom), 6'($urandom), 1'($urandom));
      end else begin
         send_request(pbrq_op_type'($urandom_range(3)), 6'($urandom), 6'($urandom),
                      1'($urandom));
      end
   endtask

   task automatic test_random(int count);
      repeat (count) random_request();
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // output register and the sequencer both fill and the input stalls.
   task automatic test_backpressure();
      drain_responses();
      hold_cycles = 400;
      test_random(40);
   endtask

   // Receiver ready: random stalls, or a long counted hold-off when requested.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Checks every response beat against the oldest prediction.
   always @(posedge clock) begin
      rq_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response beat %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[1:0] != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[7:2] != want.sel) begin
               $error("selected_thread: expected %0d, got %0d", want.sel, rsp_tdata[7:2]);
               errors++;
            end
            if (rsp_tdata[8] != want.sel_valid) begin
               $error("selected_valid: expected %0d, got %0d", want.sel_valid,
                      rsp_tdata[8]);
               errors++;
            end
            if (rsp_tdata[9] != want.switched) begin
               $error("switched: expected %0d, got %0d", want.switched, rsp_tdata[9]);
               errors++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      lvl_bitmap = '0;
      for (int i = 0; i < 64; i++) thr_queued[i] = 1'b0;
      sched_en = 1'b1;
      run_id   = 6'd0;
      run_prio = 6'd0;
      run_act  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_idle_pct = 10;
      rcv_idle_pct = 77;
      test_directed_ops();
      test_empty_queue();
      test_disabled_preemption();
      test_random(400);

      write_sched_enable(1'b0);
      snd_idle_pct = 77;
      rcv_idle_pct = 10;
      test_random(300);
      write_sched_enable(1'b1);
      test_random(150);

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random(400);
      test_backpressure();

      drain_responses();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
